// ----- hw/rtl/signed_int_to_decimal_ascii_top_defines.svh -----
// assertion macros for the signed integer to decimal text converter
// expects clk and arst_n in the scope where a macro is used
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, checked out of reset
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hw/rtl/sitda_pkg.sv -----
// shared types and constants for the decimal text converter
// no dependencies
`timescale 1ns / 1ps

package sitda_pkg;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_NINE  = 8'd57;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	// double dabble correction: a bcd digit of five or more gets three added
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SIGN,
		B_CONV,
		B_SKIP,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [3:0] bcd_adjust(input logic [3:0] digit);
		logic [3:0] res;
		res = (digit >= BCD_ADJ_MIN) ? digit + BCD_ADJ : digit;
		return res;
	endfunction

endpackage

// ----- hw/rtl/sitda_front.sv -----
// front end: accepts a value beat and splits it into sign and magnitude
// depends on sitda_pkg
`timescale 1ns / 1ps

module sitda_front
	import sitda_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  q_status_t                     q_status,
	output logic                          push,
	output logic                          push_neg,
	output logic        [VALUE_WIDTH-1:0] push_mag
);

	logic                   valid_s1;
	logic                   neg_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;

	// two's complement magnitude, most negative value wraps to its true magnitude
	assign raw = value;
	assign mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

	assign push     = valid_s1 && !q_status.full;
	assign in_ready = !valid_s1 || !q_status.full;
	assign push_neg = neg_s1;
	assign push_mag = mag_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			neg_s1 <= raw[VALUE_WIDTH-1];
			mag_s1 <= mag;
		end
	end

endmodule

// ----- hw/rtl/sitda_queue.sv -----
// two-entry queue between front and back end
// depends on sitda_pkg
`timescale 1ns / 1ps

module sitda_queue
	import sitda_pkg::*;
#(
	parameter int DATA_W = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output q_status_t         status
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/sitda_back.sv -----
// back end: double dabble conversion one bit per cycle, then one character per beat
// depends on sitda_pkg
`timescale 1ns / 1ps

module sitda_back
	import sitda_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  logic                   q_neg,
	input  logic [VALUE_WIDTH-1:0] q_mag,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             character,
	output logic                   last
);

	// decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
	localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * 4;
	localparam int CNT_W = $clog2(NDIG + 1);
	localparam int BIT_W = $clog2(VALUE_WIDTH + 1);

	back_state_t            state_q;
	back_state_t            state_d;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [BIT_W-1:0]       bits_q;
	logic [CNT_W-1:0]       digs_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic [3:0]             top;
	logic                   slot_free;
	logic                   top_zero_lead;
	logic                   load_sign;
	logic                   do_dabble;
	logic                   do_skip;
	logic                   load_digit;

	assign top           = bcd_q[BCD_W-1 -: 4];
	assign slot_free     = !out_valid_q || out_ready;
	assign top_zero_lead = (top == 4'd0) && (digs_q > CNT_W'(1));

	// per-digit correction ahead of each shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[i*4 +: 4] = bcd_adjust(bcd_q[i*4 +: 4]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					state_d = q_neg ? B_SIGN : B_CONV;
				end
			end
			B_SIGN: begin
				if (slot_free) begin
					state_d = B_CONV;
				end
			end
			B_CONV: begin
				if (bits_q == BIT_W'(1)) begin
					state_d = B_SKIP;
				end
			end
			B_SKIP: begin
				if (!top_zero_lead) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (slot_free && digs_q == CNT_W'(1)) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop        = 1'b0;
		load_sign  = 1'b0;
		do_dabble  = 1'b0;
		do_skip    = 1'b0;
		load_digit = 1'b0;
		unique case (state_q)
			B_IDLE: pop        = q_valid;
			B_SIGN: load_sign  = slot_free;
			B_CONV: do_dabble  = 1'b1;
			B_SKIP: do_skip    = top_zero_lead;
			B_EMIT: load_digit = slot_free;
			default: pop       = 1'b0;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			bits_q  <= '0;
			digs_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				bits_q <= BIT_W'(VALUE_WIDTH);
				digs_q <= CNT_W'(NDIG);
			end else begin
				if (do_dabble) begin
					bits_q <= bits_q - BIT_W'(1);
				end
				if (do_skip || load_digit) begin
					digs_q <= digs_q - CNT_W'(1);
				end
			end
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			mag_q <= q_mag;
			bcd_q <= '0;
		end else if (do_dabble) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= mag_q << 1;
		end else if (do_skip || load_digit) begin
			bcd_q <= bcd_q << 4;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_sign || load_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (load_digit) begin
			char_q <= ASCII_ZERO + {4'd0, top};
			last_q <= (digs_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii_top.sv -----
// top level of the signed integer to decimal text converter
// depends on sitda_pkg, sitda_front, sitda_queue, sitda_back and the defines header
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_ready  | value (VALUE_WIDTH bits, signed)
//  output  | out_valid / out_ready| character (8 bits), last (1 bit)
//
// the back end runs the bit-per-cycle double dabble loop on a number, then skips its leading
// zeros and emits the digits, a minus sign first when it is negative; NDIG, the digit count
// of 2^(VALUE_WIDTH-1), sets how many digits the skip and the emitter work through.
// the front stage and two-entry queue take up to three more numbers meanwhile.
// reset is asynchronous and clears only control state.
// a stalled output holds the back end; the queue keeps the front accepting.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top
	import sitda_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    character,
	output logic                          last
);

	q_status_t              q_status;
	logic                   push;
	logic                   push_neg;
	logic [VALUE_WIDTH-1:0] push_mag;
	logic                   pop;
	logic [VALUE_WIDTH:0]   pop_data;
	logic                   is_minus;
	logic                   char_legal;

	// accept and classify
	sitda_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.q_status (q_status),
		.push     (push),
		.push_neg (push_neg),
		.push_mag (push_mag)
	);

	// decoupling queue
	sitda_queue #(
		.DATA_W(VALUE_WIDTH + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_neg, push_mag}),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// convert and emit
	sitda_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_status.empty),
		.q_neg     (pop_data[VALUE_WIDTH]),
		.q_mag     (pop_data[VALUE_WIDTH-1:0]),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	// character classes for the checks
	assign is_minus   = (character == ASCII_MINUS);
	assign char_legal = is_minus || ((character >= ASCII_ZERO) && (character <= ASCII_NINE));

	// checks
	`SITDA_ASSERT_NOW(a_char_legal, out_valid, char_legal, "illegal character on output")
	`SITDA_ASSERT_NOW(a_minus_not_last, out_valid && is_minus, !last, "minus sign flagged last")
	`SITDA_ASSERT_NEXT(a_queue_drain, q_status.full, !q_status.empty, "queue went empty from full")

endmodule
